/* src/ddo_pkg.sv */
`default_nettype none
package ddo_pkg;

	localparam int CordicStepsDef = 16;
	localparam int PosWidthDef    = 40;

	// CORDIC datapath width: Q2.30 plus headroom
	localparam int CW = 34;

	localparam logic [31:0] YAW_GAIN_RST = 32'd2734261102;
	localparam logic [CW-1:0] CORDIC_K0  = CW'(652032874);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ANG  = 2'd2;

	typedef struct packed {
		logic signed [31:0] left_wheel_pos;
		logic signed [31:0] right_wheel_pos;
	} in_item_t;

	typedef struct packed {
		logic signed [39:0] pose_x;
		logic signed [39:0] pose_y;
		logic [31:0]        heading;
		logic signed [39:0] sensor_x;
		logic signed [39:0] sensor_y;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic yaw_step;
		logic rot_init;
		logic rot_iter;
		logic phase_sens;
		logic sel_sin;
		logic mul_en;
		logic add_en;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic primed;
		logic rot_last;
	} dp_sts_t;

	// arctangent of 2^-i, 2^32 per turn
	function automatic logic [31:0] atan_ent(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* src/ddo_ctrl.sv */
`default_nettype none
module ddo_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire ddo_pkg::dp_sts_t  sts,
	output ddo_pkg::dp_cmd_t       cmd
);
	import ddo_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_YAW, S_ROT_INIT, S_ROT_ITER,
		S_MUL_C, S_ADD_C, S_MUL_S, S_ADD_S, S_OUT
	} state_t;

	state_t state_q;
	logic   sens_q;     // second rotation pass: sensor pose
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.phase_sens = sens_q;
		unique case (state_q)
			S_IDLE:     cmd.load_in  = in_valid;
			S_YAW:      cmd.yaw_step = 1'b1;
			S_ROT_INIT: cmd.rot_init = 1'b1;
			S_ROT_ITER: cmd.rot_iter = 1'b1;
			S_MUL_C:    cmd.mul_en   = 1'b1;
			S_ADD_C:    cmd.add_en   = 1'b1;
			S_MUL_S: begin
				cmd.mul_en  = 1'b1;
				cmd.sel_sin = 1'b1;
			end
			S_ADD_S: begin
				cmd.add_en  = 1'b1;
				cmd.sel_sin = 1'b1;
			end
			S_OUT:      cmd.out_load = !out_valid_q || out_ready;
			default:    cmd = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sens_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (in_valid) begin
					sens_q  <= !sts.primed;
					state_q <= sts.primed ? S_YAW : S_ROT_INIT;
				end
				S_YAW:      state_q <= S_ROT_INIT;
				S_ROT_INIT: state_q <= S_ROT_ITER;
				S_ROT_ITER: if (sts.rot_last) state_q <= S_MUL_C;
				S_MUL_C:    state_q <= S_ADD_C;
				S_ADD_C:    state_q <= S_MUL_S;
				S_MUL_S:    state_q <= S_ADD_S;
				S_ADD_S: begin
					if (sens_q) begin
						state_q <= S_OUT;
					end else begin
						sens_q  <= 1'b1;
						state_q <= S_ROT_INIT;
					end
				end
				S_OUT:      if (cmd.out_load) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/ddo_dp.sv */
`default_nettype none
module ddo_dp #(
	parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDef,
	parameter int POS_WIDTH    = ddo_pkg::PosWidthDef
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ddo_pkg::dp_cmd_t                cmd,
	output ddo_pkg::dp_sts_t                     sts,
	input  wire ddo_pkg::in_item_t               in_data,
	output ddo_pkg::out_item_t                   out_data,
	input  wire logic                            cfg_valid,
	input  wire logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [31:0]                     cfg_data
);
	import ddo_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	// configuration
	logic [31:0] yaw_gain_q;
	logic [19:0] off_len_q;
	logic [31:0] off_ang_q;

	// odometry state
	logic [31:0]          prev_l_q, prev_r_q;
	logic                 primed_q;
	logic signed [31:0]   dl_q, dr_q;
	logic signed [31:0]   travel_q;
	logic [31:0]          yaw_q;
	logic [POS_WIDTH-1:0] acc_x_q, acc_y_q;
	logic [POS_WIDTH-1:0] sens_x_q, sens_y_q;

	// rotation unit
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 flip_q;
	logic [IW-1:0]        it_q;

	// shared multiplier
	logic [POS_WIDTH-1:0] mul_q;
	out_item_t            out_q;

	assign sts.primed   = primed_q;
	assign sts.rot_last = (it_q == IW'(CORDIC_STEPS - 1));
	assign out_data     = out_q;

	// heading step and mean travel
	logic signed [32:0] wd_diff, wd_sum;
	logic signed [65:0] yaw_prod;
	assign wd_diff  = {dl_q[31], dl_q} - {dr_q[31], dr_q};
	assign wd_sum   = {dl_q[31], dl_q} + {dr_q[31], dr_q};
	assign yaw_prod = wd_diff * $signed({1'b0, yaw_gain_q});

	// half-turn fold of the rotation angle
	logic [31:0]          rot_ang;
	logic signed [31:0]   ang_s;
	logic                 fold_pos, fold_neg;
	assign rot_ang  = cmd.phase_sens ? (yaw_q + off_ang_q) : yaw_q;
	assign ang_s    = $signed(rot_ang);
	assign fold_pos = ang_s > 32'sh40000000;
	assign fold_neg = ang_s < -32'sh40000000;

	// one CORDIC micro-rotation
	logic signed [CW-1:0] xs, ys, atn;
	assign xs  = x_q >>> it_q;
	assign ys  = y_q >>> it_q;
	assign atn = $signed(CW'(atan_ent(5'(it_q))));

	// product with cos or sin, Q2.30 dropped
	logic signed [CW-1:0] c_fin, s_fin, opb;
	logic signed [31:0]   opa;
	logic signed [65:0]   mprod, mshift;
	assign c_fin  = flip_q ? -x_q : x_q;
	assign s_fin  = flip_q ? -y_q : y_q;
	assign opa    = cmd.phase_sens ? $signed({12'd0, off_len_q}) : travel_q;
	assign opb    = cmd.sel_sin ? s_fin : c_fin;
	assign mprod  = opa * opb;
	assign mshift = mprod >>> 30;

	// sign-extended views for the result
	logic signed [63:0] px_e, py_e, sx_e, sy_e;
	assign px_e = 64'($signed(acc_x_q));
	assign py_e = 64'($signed(acc_y_q));
	assign sx_e = 64'($signed(sens_x_q));
	assign sy_e = 64'($signed(sens_y_q));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_q <= YAW_GAIN_RST;
			off_len_q  <= '0;
			off_ang_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_YAW_GAIN:   yaw_gain_q <= cfg_data;
				REG_OFFSET_LEN: off_len_q  <= cfg_data[19:0];
				REG_OFFSET_ANG: off_ang_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= '0;
			prev_r_q <= '0;
			primed_q <= 1'b0;
			yaw_q    <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else begin
			if (cmd.load_in) begin
				prev_l_q <= in_data.left_wheel_pos;
				prev_r_q <= in_data.right_wheel_pos;
				primed_q <= 1'b1;
			end
			if (cmd.yaw_step)
				yaw_q <= yaw_q + yaw_prod[47:16];
			if (cmd.add_en && !cmd.phase_sens) begin
				if (cmd.sel_sin)
					acc_y_q <= acc_y_q + mul_q;
				else
					acc_x_q <= acc_x_q + mul_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dl_q <= $signed(in_data.left_wheel_pos - prev_l_q);
			dr_q <= $signed(in_data.right_wheel_pos - prev_r_q);
		end
		if (cmd.yaw_step)
			travel_q <= wd_sum[32:1];
		if (cmd.rot_init) begin
			x_q    <= $signed(CORDIC_K0);
			y_q    <= '0;
			it_q   <= '0;
			flip_q <= fold_pos || fold_neg;
			if (fold_pos)
				z_q <= CW'(ang_s) - CW'(64'sh80000000);
			else if (fold_neg)
				z_q <= CW'(ang_s) + CW'(64'sh80000000);
			else
				z_q <= CW'(ang_s);
		end else if (cmd.rot_iter) begin
			it_q <= it_q + 1'b1;
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
		if (cmd.mul_en)
			mul_q <= mshift[POS_WIDTH-1:0];
		if (cmd.add_en && cmd.phase_sens) begin
			if (cmd.sel_sin)
				sens_y_q <= acc_y_q + mul_q;
			else
				sens_x_q <= acc_x_q + mul_q;
		end
		if (cmd.out_load) begin
			out_q.pose_x   <= px_e[39:0];
			out_q.pose_y   <= py_e[39:0];
			out_q.heading  <= yaw_q;
			out_q.sensor_x <= sx_e[39:0];
			out_q.sensor_y <= sy_e[39:0];
		end
	end

endmodule
`default_nettype wire

/* src/diff_drive_odometry_unit.sv */
// Differential-drive dead reckoning.
// Input channel (in_valid/in_ready/in_data): absolute left and right wheel
// distances, Q15.16 metres. Output channel (out_valid/out_ready/out_data):
// body pose X/Y, heading as a binary angle, and the offset sensor X/Y.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): yaw gain,
// sensor offset length and angle; always ready, write only while idle.
// One item at a time. A primed item runs from transfer to result valid
// through one heading step, then two passes through the shared iterative
// CORDIC (body, then sensor), each one start step, CORDIC_STEPS rotations
// and a multiply and add for cosine and for sine on the one shared
// multiplier, then the load of the output register. The first item after
// reset only records the wheels and runs the sensor pass alone. The next
// transfer can be taken in the cycle after the result is loaded, once the
// sequencer is back in idle.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a finished item holds in the sequencer
// until the register is free. Reset clears pose, heading and wheel history
// and restores the register defaults.
`default_nettype none
module diff_drive_odometry_unit #(
	parameter int CORDIC_STEPS = ddo_pkg::CordicStepsDef,
	parameter int POS_WIDTH    = ddo_pkg::PosWidthDef
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ddo_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output ddo_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import ddo_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ddo_dp #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.POS_WIDTH    (POS_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef SYNTHESIS
	// a transfer in starts work: no second transfer the cycle after
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while item in progress");

	// a new result lands as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while sequencer busy");

	// the last rotation hands over to the cosine multiply
	a_rot_last_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rot_iter && sts.rot_last |=> cmd.mul_en && !cmd.sel_sin)
		else $error("rotation pass did not hand over to multiply");
`endif

endmodule
`default_nettype wire

/* bench/diff_drive_odometry_unit_tb.sv */
`default_nettype none
module diff_drive_odometry_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ddo_pkg::*;

	localparam int STEPS    = 16;
	localparam int WATCHDOG = 20000;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// pose tracker: wheel history, heading, position and registers
	class pose_scoreboard;
		logic [31:0] gain, off_ang;
		logic [19:0] off_len;
		logic [31:0] last_l, last_r, yaw;
		logic signed [39:0] px, py;
		bit primed;
		out_item_t pending[$];
		int errors;

		function void clear();
			gain = YAW_GAIN_RST; off_ang = 0; off_len = 0;
			last_l = 0; last_r = 0; yaw = 0; px = 0; py = 0;
			primed = 0; errors = 0;
			pending.delete();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				REG_YAW_GAIN:   gain = v;
				REG_OFFSET_LEN: off_len = v[19:0];
				REG_OFFSET_ANG: off_ang = v;
				default: ;
			endcase
		endfunction

		// rotation-mode sine/cosine with half-turn fold
		function void rotate(logic [31:0] ang, output longint c, output longint s);
			longint a, x, y, xs, ys;
			bit flip;
			a = longint'($signed(ang));
			flip = 0;
			x = 652032874; y = 0;
			if (a > 64'sh40000000) begin
				a -= 64'sh80000000; flip = 1;
			end else if (a < -64'sh40000000) begin
				a += 64'sh80000000; flip = 1;
			end
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (a >= 0) begin
					x -= ys; y += xs; a -= longint'(atan_ent(5'(i)));
				end else begin
					x += ys; y -= xs; a += longint'(atan_ent(5'(i)));
				end
			end
			if (flip) begin
				x = -x; y = -y;
			end
			c = x; s = y;
		endfunction

		function void note_input(in_item_t it);
			longint dl, dr, trav, c, s, prod;
			out_item_t e;
			if (primed) begin
				dl = longint'($signed(it.left_wheel_pos - last_l));
				dr = longint'($signed(it.right_wheel_pos - last_r));
				prod = (dl - dr) * longint'({32'b0, gain});
				yaw += 32'(prod >>> 16);
				trav = (dl + dr) >>> 1;
				rotate(yaw, c, s);
				px += 40'((trav * c) >>> 30);
				py += 40'((trav * s) >>> 30);
			end
			last_l = it.left_wheel_pos; last_r = it.right_wheel_pos;
			primed = 1;
			rotate(yaw + off_ang, c, s);
			e.pose_x = px; e.pose_y = py; e.heading = yaw;
			e.sensor_x = px + 40'((longint'(off_len) * c) >>> 30);
			e.sensor_y = py + 40'((longint'(off_len) * s) >>> 30);
			pending = {pending, e};
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got); errors++; return;
			end
			e = pending.pop_front();
			if (got.pose_x !== e.pose_x) begin
				$error("pose_x exp %h got %h", e.pose_x, got.pose_x); errors++;
			end
			if (got.pose_y !== e.pose_y) begin
				$error("pose_y exp %h got %h", e.pose_y, got.pose_y); errors++;
			end
			if (got.heading !== e.heading) begin
				$error("heading exp %h got %h", e.heading, got.heading); errors++;
			end
			if (got.sensor_x !== e.sensor_x) begin
				$error("sensor_x exp %h got %h", e.sensor_x, got.sensor_x); errors++;
			end
			if (got.sensor_y !== e.sensor_y) begin
				$error("sensor_y exp %h got %h", e.sensor_y, got.sensor_y); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	in_item_t in_data = '0;
	out_item_t out_data;

	pose_scoreboard sb;
	int idle_cycles = 0, n_in = 0, n_out = 0;
	bit hold_rx = 0;
	logic [31:0] wl = 0, wr = 0;

	diff_drive_odometry_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
	endfunction

	// transfers seen at the edge feed the scoreboard; watchdog on no progress
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(in_data); n_in++;
			end
			if (out_valid && out_ready) begin
				sb.check_result(out_data); n_out++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready) || (!in_valid && sb.pending.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random readiness, long hold-off on request
	always @(posedge clk) begin
		if (hold_rx || !arst_n)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : 1'b0;
	end

	// offer one item; valid is left high for a following item
	task automatic send_wheels(logic [31:0] l, logic [31:0] r);
		in_data <= '{left_wheel_pos: l, right_wheel_pos: r};
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_gap(logic [31:0] l, logic [31:0] r);
		int g;
		send_wheels(l, r);
		g = gap_len();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * STEPS + 20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_index <= idx; cfg_data <= v; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	// motion: mostly deltas around the last reading, now and then a fresh random reading
	task automatic move_random();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0) begin
			wl = $urandom; wr = $urandom;
		end else if (k < 4) begin
			wl += 32'($signed($urandom_range(0, 2000000)) - 1000000);
			wr += 32'($signed($urandom_range(0, 2000000)) - 1000000);
		end else begin
			wl += 32'($signed($urandom_range(0, 40000)) - 20000);
			wr += 32'($signed($urandom_range(0, 40000)) - 20000);
		end
		send_gap(wl, wr);
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: first item only records, then extremes and wrap
		send_gap(32'h7FFFFFFF, 32'h80000000);
		send_gap(32'h80000000, 32'h7FFFFFFF);
		send_gap(32'h80000000, 32'h80000000);
		send_gap(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_gap(32'h00000000, 32'hFFFFFFFF);
		send_gap(32'h00010000, 32'h00010000);
		send_gap(32'h00030000, 32'h00010000);
		send_gap(32'h00030000, 32'h00050000);
		send_gap(32'hFFFFFFFF, 32'h00000000);
		drain();
		write_cfg(REG_YAW_GAIN, 32'hFFFFFFFF);
		write_cfg(REG_OFFSET_LEN, 32'hFFFFFFFF);
		write_cfg(REG_OFFSET_ANG, 32'hFFFFFFFF);
		write_cfg(REG_UNUSED, 32'h12345678);
		send_gap(32'h00020000, 32'h00000000);
		send_gap(32'h80000000, 32'h00000000);
		send_gap(32'h40000000, 32'hC0000000);
		send_gap(32'h40000000, 32'hC0000000);
		drain();
		write_cfg(REG_YAW_GAIN, 32'h0);
		write_cfg(REG_OFFSET_LEN, 32'h0);
		write_cfg(REG_OFFSET_ANG, 32'h40000000);
		send_gap(32'h7FFF0000, 32'h7FFF0000);
		send_gap(32'h00000000, 32'h00000000);
		send_gap(32'hAAAAAAAA, 32'h55555555);
		send_gap(32'h55555555, 32'hAAAAAAAA);
		drain();
		wl = 32'h55555555; wr = 32'hAAAAAAAA;

		// random phases with fresh register settings
		for (int ph = 0; ph < 10; ph++) begin
			write_cfg(REG_YAW_GAIN, (ph == 0) ? YAW_GAIN_RST : $urandom);
			write_cfg(REG_OFFSET_LEN, $urandom);
			write_cfg(REG_OFFSET_ANG, (ph == 1) ? 32'h80000000 : $urandom);
			if (ph == 3) begin
				hold_rx = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						hold_rx = 0;
					end
				join_none
			end
			for (int i = 0; i < 100; i++) begin
				move_random();
				if (ph == 5 && i == 50) drain();
			end
			drain();
		end

		drain();
		$display("Ran %0d wheel transfers and %0d pose results over 13 register settings,",
			n_in, n_out);
		$display("including wheel wrap, extreme gains, stalls and directed extremes.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
